// ----- hdl/qts_pkg.sv -----
// Shared types, constants and character helpers for the query token scanner.
package qts_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int FIELD_BITS = 16;
   localparam int RSP_DEPTH = 4;
   localparam int PTR_BITS = $clog2(RSP_DEPTH);
   localparam int CNT_BITS = $clog2(RSP_DEPTH + 1);
   localparam int KW_LEN = 6;

   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   typedef enum logic {
      FUNC_BYTE = 1'b0,
      FUNC_END = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      KIND_SEMI = 3'd0,
      KIND_STAR = 3'd1,
      KIND_STRING = 3'd2,
      KIND_NUMBER = 3'd3,
      KIND_IDENT = 3'd4,
      KIND_INSERT = 3'd5,
      KIND_SELECT = 3'd6,
      KIND_END = 3'd7
   } token_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_STRING = 3'd1,
      MODE_INT = 3'd2,
      MODE_DOT = 3'd3,
      MODE_FRAC = 3'd4,
      MODE_IDENT = 3'd5
   } scan_mode_type;

   typedef struct packed {
      token_kind_type kind;
      logic [FIELD_BITS-1:0] start_offset;
      logic [FIELD_BITS-1:0] token_length;
      logic [FIELD_BITS-1:0] line_number;
      logic last_of_run;
   } rsp_type;

   function automatic logic is_digit(logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (b == CH_UNDERSCORE);
   endfunction

   function automatic logic [7:0] kw_insert_char(logic [2:0] idx);
      case (idx)
         3'd0: return 8'h49;  // I
         3'd1: return 8'h4E;  // N
         3'd2: return 8'h53;  // S
         3'd3: return 8'h45;  // E
         3'd4: return 8'h52;  // R
         3'd5: return 8'h54;  // T
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] kw_select_char(logic [2:0] idx);
      case (idx)
         3'd0: return 8'h53;  // S
         3'd1: return 8'h45;  // E
         3'd2: return 8'h4C;  // L
         3'd3: return 8'h45;  // E
         3'd4: return 8'h43;  // C
         3'd5: return 8'h54;  // T
         default: return 8'h00;
      endcase
   endfunction

   // bit 0: INSERT still possible, bit 1: SELECT still possible
   function automatic logic [1:0] kw_update(logic [1:0] km, logic idx_ok, logic [2:0] idx,
                                            logic [7:0] b);
      logic [1:0] r;
      r = km;
      if (!idx_ok) begin
         r = 2'b00;
      end else begin
         if (kw_insert_char(idx) != b) r[0] = 1'b0;
         if (kw_select_char(idx) != b) r[1] = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- hdl/qts_scan.sv -----
// Scanner state registers and the per-byte token decode.
module qts_scan import qts_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_valid,
   input  func_type             step_func,
   input  logic [7:0]           step_byte,
   output rsp_type              res0,
   output rsp_type              res1,
   output logic [1:0]           res_count
);

   localparam logic [POSITION_BITS-1:0] LINE_RESET = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] KW_LEN_P = POSITION_BITS'(KW_LEN);

   function automatic logic [POSITION_BITS-1:0] sat_add(logic [POSITION_BITS-1:0] v,
                                                        logic [1:0] d);
      logic [POSITION_BITS:0] s;
      s = {1'b0, v} + (POSITION_BITS + 1)'(d);
      return s[POSITION_BITS] ? {POSITION_BITS{1'b1}} : s[POSITION_BITS-1:0];
   endfunction

   scan_mode_type mode_ff, mode_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] len_ff, len_in;
   logic [1:0] km_ff, km_in;

   logic b_digit, b_alpha, b_semi, b_star, b_quote, b_dot, b_newline;
   logic flush, restart, second;
   rsp_type flush_tok, second_tok;
   token_kind_type flush_kind;

   assign b_digit = is_digit(step_byte);
   assign b_alpha = is_alpha(step_byte);
   assign b_semi = (step_byte == CH_SEMI);
   assign b_star = (step_byte == CH_STAR);
   assign b_quote = (step_byte == CH_QUOTE);
   assign b_dot = (step_byte == CH_DOT);
   assign b_newline = (step_byte == CH_NEWLINE);

   // token close / restart decode
   always_comb begin
      flush = 1'b0;
      restart = 1'b0;
      if (step_func == FUNC_END) begin
         flush = (mode_ff != MODE_IDLE);
      end else begin
         case (mode_ff)
            MODE_STRING: begin
               flush = b_quote;
            end
            MODE_INT: begin
               flush = !b_digit && !b_dot;
               restart = flush;
            end
            MODE_DOT, MODE_FRAC: begin
               flush = !b_digit;
               restart = flush;
            end
            MODE_IDENT: begin
               flush = !b_alpha && !b_digit;
               restart = flush;
            end
            default: begin
               restart = 1'b1;
            end
         endcase
      end
      second = (step_func == FUNC_END) || (restart && (b_semi || b_star));
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      start_in = start_ff;
      pos_in = sat_add(pos_ff, 2'd1);
      line_in = line_ff;
      len_in = len_ff;
      km_in = km_ff;
      if (step_func == FUNC_END) begin
         mode_in = MODE_IDLE;
         start_in = '0;
         pos_in = '0;
         line_in = LINE_RESET;
         len_in = '0;
         km_in = 2'b11;
      end else begin
         case (mode_ff)
            MODE_STRING: begin
               len_in = sat_add(len_ff, 2'd1);
               if (b_newline) line_in = sat_add(line_ff, 2'd1);
               if (b_quote) mode_in = MODE_IDLE;
            end
            MODE_INT: begin
               if (b_digit) len_in = sat_add(len_ff, 2'd1);
               else if (b_dot) mode_in = MODE_DOT;
            end
            MODE_DOT: begin
               if (b_digit) begin
                  len_in = sat_add(len_ff, 2'd2);
                  mode_in = MODE_FRAC;
               end
            end
            MODE_FRAC: begin
               if (b_digit) len_in = sat_add(len_ff, 2'd1);
            end
            MODE_IDENT: begin
               if (b_alpha || b_digit) begin
                  km_in = kw_update(km_ff, len_ff < KW_LEN_P, len_ff[2:0], step_byte);
                  len_in = sat_add(len_ff, 2'd1);
               end
            end
            default: begin
            end
         endcase
         if (restart) begin
            start_in = pos_ff;
            len_in = LINE_RESET;
            mode_in = MODE_IDLE;
            if (b_quote) begin
               mode_in = MODE_STRING;
            end else if (b_digit) begin
               mode_in = MODE_INT;
            end else if (b_alpha) begin
               mode_in = MODE_IDENT;
               km_in = kw_update(2'b11, 1'b1, 3'd0, step_byte);
            end else if (!b_semi && !b_star) begin
               len_in = '0;
            end
         end
      end
   end

   // outputs
   always_comb begin
      case (mode_ff)
         MODE_STRING: flush_kind = KIND_STRING;
         MODE_INT, MODE_DOT, MODE_FRAC: flush_kind = KIND_NUMBER;
         MODE_IDENT: begin
            flush_kind = KIND_IDENT;
            if (len_ff == KW_LEN_P) begin
               if (km_ff[0]) flush_kind = KIND_INSERT;
               else if (km_ff[1]) flush_kind = KIND_SELECT;
            end
         end
         default: flush_kind = KIND_END;
      endcase

      flush_tok.kind = flush_kind;
      flush_tok.start_offset = FIELD_BITS'(start_ff);
      flush_tok.token_length = (mode_ff == MODE_STRING && step_func == FUNC_BYTE) ?
                               FIELD_BITS'(sat_add(len_ff, 2'd1)) : FIELD_BITS'(len_ff);
      flush_tok.line_number = FIELD_BITS'(line_ff);
      flush_tok.last_of_run = !second;

      second_tok.kind = (step_func == FUNC_END) ? KIND_END : (b_semi ? KIND_SEMI : KIND_STAR);
      second_tok.start_offset = FIELD_BITS'(pos_ff);
      second_tok.token_length = (step_func == FUNC_END) ? '0 : FIELD_BITS'(1);
      second_tok.line_number = FIELD_BITS'(line_ff);
      second_tok.last_of_run = 1'b1;

      if (flush) begin
         res0 = flush_tok;
         res1 = second_tok;
         res_count = second ? 2'd2 : 2'd1;
      end else begin
         res0 = second_tok;
         res1 = second_tok;
         res_count = second ? 2'd1 : 2'd0;
      end
      if (!step_valid) res_count = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         start_ff <= '0;
         pos_ff <= '0;
         line_ff <= LINE_RESET;
         len_ff <= '0;
         km_ff <= 2'b11;
      end else if (step_valid) begin
         mode_ff <= mode_in;
         start_ff <= start_in;
         pos_ff <= pos_in;
         line_ff <= line_in;
         len_ff <= len_in;
         km_ff <= km_in;
      end
   end

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      step_valid && step_func == FUNC_END |=>
         mode_ff == MODE_IDLE && pos_ff == '0 && line_ff == LINE_RESET)
      else $error("scanner state not cleared after end of source");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      res_count == 2'd2 |-> !res0.last_of_run && res1.last_of_run)
      else $error("last marker misplaced in token pair");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      step_valid && step_func == FUNC_END |-> res_count != 2'd0)
      else $error("end of source produced no token");

endmodule

// ----- hdl/qts_rsp_fifo.sv -----
// Token queue: takes up to two tokens a cycle, delivers one.
module qts_rsp_fifo import qts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  rsp_type    push0,
   input  rsp_type    push1,
   output logic       has_room,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   rsp_type mem [RSP_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data = mem[rd_ptr_ff];
   assign pop = rsp_valid && rsp_ready;
   assign has_room = (count_ff <= CNT_BITS'(RSP_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in = count_ff + CNT_BITS'(push_count) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem[wr_ptr_ff] <= push0;
      if (push_count == 2'd2) mem[wr_ptr_ff + PTR_BITS'(1)] <= push1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |-> has_room)
      else $error("token queue written without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(RSP_DEPTH))
      else $error("token queue count out of range");

endmodule

// ----- hdl/query_token_scanner_top.sv -----
// Query token scanner: byte stream in, token stream out.
//
// req channel: one request per source byte (tuser = 0, tdata = byte) or an
// end-of-source request (tuser = 1, tdata ignored). rsp channel: tokens with
// kind in tuser and start offset, length and line in tdata; tlast marks the
// final token caused by one request. A request causes zero, one or two tokens.
// A request is held in the input register, then its tokens go to the token queue that drives rsp.
// Throughput: one request per cycle while each request causes at most one
// token and rsp_tready stays high; a request that causes two tokens holds the
// single rsp port for both of them. The rate is set by the four-entry token
// queue, which accepts a new request only while two entries are free.
// When rsp_tready is low the queue fills; once fewer than two entries remain the
// input register holds its request and req_tready drops; nothing is lost.
// Reset (synchronous, active high) empties the queue and the input register
// and returns the scanner to offset 0, line 1, no token open. An end-of-
// source request returns the scanner to the same state.
module query_token_scanner_top import qts_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] source_byte
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] start_offset, [31:16] token_length,
                                    // [47:32] line_number
   output logic [2:0]  rsp_tuser,   // [2:0] token_kind
   output logic        rsp_tlast
);

   logic stage_valid_ff, stage_valid_in;
   func_type stage_func_ff;
   logic [7:0] stage_byte_ff;
   logic advance;
   logic has_room;
   rsp_type res0, res1, rsp_data;
   logic [1:0] res_count;

   assign advance = stage_valid_ff && has_room;
   assign req_tready = !stage_valid_ff || advance;
   assign stage_valid_in = (req_tvalid && req_tready) || (stage_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_func_ff <= func_type'(req_tuser);
         stage_byte_ff <= req_tdata;
      end
   end

   qts_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .step_valid(advance),
      .step_func(stage_func_ff),
      .step_byte(stage_byte_ff),
      .res0(res0),
      .res1(res1),
      .res_count(res_count)
   );

   qts_rsp_fifo u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push_count(res_count),
      .push0(res0),
      .push1(res1),
      .has_room(has_room),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_data(rsp_data)
   );

   assign rsp_tdata = {rsp_data.line_number, rsp_data.token_length, rsp_data.start_offset};
   assign rsp_tuser = rsp_data.kind;
   assign rsp_tlast = rsp_data.last_of_run;

endmodule

// ----- dv/tb_query_token_scanner_top.sv -----
// Self-checking testbench for the query token scanner: bursty byte stream in, tokens checked.
`timescale 1ns / 1ps

module tb_query_token_scanner_top;
   import qts_pkg::*;

   localparam int unsigned POS_MAX = (1 << POSITION_BITS_DEFAULT) - 1;
   localparam logic [47:0] KW_INSERT_TXT = "INSERT";
   localparam logic [47:0] KW_SELECT_TXT = "SELECT";
   localparam int RANDOM_REQUESTS = 470;

   typedef struct {
      func_type func;
      logic [7:0] ch;
   } src_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] source_byte
   logic        req_tuser = 1'b0;    // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // [15:0] start_offset, [31:16] token_length,
                                     // [47:32] line_number
   logic [2:0]  rsp_tuser;           // [2:0] token_kind
   logic        rsp_tlast;

   src_request_type req_pend_q[$];
   rsp_type      step_tokens[$];
   rsp_type      tokens_due[$];

   // scanner shadow state
   scan_mode_type sc_mode = MODE_IDLE;
   int unsigned   sc_start = 0;
   int unsigned   sc_pos = 0;
   int unsigned   sc_line = 1;
   int unsigned   sc_len = 0;
   logic [1:0]    sc_kw = 2'b11;

   int n_req = 0;
   int n_src = 0;
   int n_tok = 0;
   int n_err = 0;
   bit kind_seen[8];

   int gap_left = 0;
   int burst_left = 1;
   int stall_mode = 0;
   int stall_left = 0;

   query_token_scanner_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------- token predictor ----------------

   function automatic int unsigned sat_inc(int unsigned v, int unsigned d);
      return (v + d > POS_MAX) ? POS_MAX : v + d;
   endfunction

   function automatic logic digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic word_ch(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
   endfunction

   function automatic logic [1:0] kw_step(logic [1:0] km, int unsigned idx, logic [7:0] c);
      logic [1:0] r;
      r = km;
      if (idx >= 6) return 2'b00;
      if (KW_INSERT_TXT[8*(5-idx) +: 8] != c) r[0] = 1'b0;
      if (KW_SELECT_TXT[8*(5-idx) +: 8] != c) r[1] = 1'b0;
      return r;
   endfunction

   task automatic put_token(token_kind_type k, int unsigned st, int unsigned ln);
      rsp_type t;
      t.kind = k;
      t.start_offset = st[15:0];
      t.token_length = ln[15:0];
      t.line_number = sc_line[15:0];
      t.last_of_run = 1'b0;
      step_tokens.push_back(t);
   endtask

   task automatic close_token();
      token_kind_type k;
      k = KIND_IDENT;
      case (sc_mode)
         MODE_STRING: k = KIND_STRING;
         MODE_INT, MODE_DOT, MODE_FRAC: k = KIND_NUMBER;
         MODE_IDENT: begin
            if (sc_len == 6 && sc_kw[0]) k = KIND_INSERT;
            else if (sc_len == 6 && sc_kw[1]) k = KIND_SELECT;
         end
         default: ;
      endcase
      if (sc_mode != MODE_IDLE) put_token(k, sc_start, sc_len);
      sc_mode = MODE_IDLE;
   endtask

   task automatic open_token(logic [7:0] c);
      sc_start = sc_pos;
      sc_len = 1;
      if (c == CH_SEMI) put_token(KIND_SEMI, sc_pos, 1);
      else if (c == CH_STAR) put_token(KIND_STAR, sc_pos, 1);
      else if (c == CH_QUOTE) sc_mode = MODE_STRING;
      else if (digit_ch(c)) sc_mode = MODE_INT;
      else if (word_ch(c)) begin
         sc_mode = MODE_IDENT;
         sc_kw = kw_step(2'b11, 0, c);
      end else sc_len = 0;
   endtask

   task automatic clear_scanner();
      sc_mode = MODE_IDLE;
      sc_start = 0;
      sc_pos = 0;
      sc_line = 1;
      sc_kw = 2'b11;
      sc_len = 0;
   endtask

   task automatic lex_request(func_type f, logic [7:0] c);
      step_tokens.delete();
      if (f == FUNC_END) begin
         close_token();
         put_token(KIND_END, sc_pos, 0);
         clear_scanner();
      end else begin
         case (sc_mode)
            MODE_STRING: begin
               sc_len = sat_inc(sc_len, 1);
               if (c == CH_NEWLINE) sc_line = sat_inc(sc_line, 1);
               if (c == CH_QUOTE) close_token();
            end
            MODE_INT: begin
               if (digit_ch(c)) sc_len = sat_inc(sc_len, 1);
               else if (c == CH_DOT) sc_mode = MODE_DOT;
               else begin
                  close_token();
                  open_token(c);
               end
            end
            MODE_DOT: begin
               if (digit_ch(c)) begin
                  sc_len = sat_inc(sc_len, 2);
                  sc_mode = MODE_FRAC;
               end else begin
                  close_token();
                  open_token(c);
               end
            end
            MODE_FRAC: begin
               if (digit_ch(c)) sc_len = sat_inc(sc_len, 1);
               else begin
                  close_token();
                  open_token(c);
               end
            end
            MODE_IDENT: begin
               if (word_ch(c) || digit_ch(c)) begin
                  sc_kw = kw_step(sc_kw, sc_len, c);
                  sc_len = sat_inc(sc_len, 1);
               end else begin
                  close_token();
                  open_token(c);
               end
            end
            default: begin
               sc_mode = MODE_IDLE;
               open_token(c);
            end
         endcase
         sc_pos = sat_inc(sc_pos, 1);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
   endtask

   // ---------------- stimulus builders ----------------

   task automatic add_char(logic [7:0] c);
      src_request_type r;
      r.func = FUNC_BYTE;
      r.ch = c;
      req_pend_q.push_back(r);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   task automatic add_end(logic [7:0] junk);
      src_request_type r;
      r.func = FUNC_END;
      r.ch = junk;
      req_pend_q.push_back(r);
   endtask

   function automatic logic [7:0] rand_word_ch();
      case ($urandom_range(0, 3))
         0: return 8'(8'h61 + $urandom_range(0, 25));
         1: return 8'(8'h41 + $urandom_range(0, 25));
         2: return 8'(8'h30 + $urandom_range(0, 9));
         default: return CH_UNDERSCORE;
      endcase
   endfunction

   task automatic add_fragment();
      string s;
      int n;
      logic [7:0] c;
      case ($urandom_range(0, 24))
         0, 1: add_text("INSERT");
         2, 3: add_text("SELECT");
         4, 5: begin
            // keyword near misses
            s = $urandom_range(0, 1) ? "INSERT" : "SELECT";
            case ($urandom_range(0, 2))
               0: begin
                  n = $urandom_range(0, 5);
                  s[n] = s[n] | 8'h20;
               end
               1: s = s.substr(0, $urandom_range(0, 4));
               default: begin
                  s = {s, "_"};
                  s[6] = rand_word_ch();
               end
            endcase
            add_text(s);
         end
         6, 7, 8: begin
            c = rand_word_ch();
            while (digit_ch(c)) c = rand_word_ch();
            add_char(c);
            n = $urandom_range(0, 8);
            repeat (n) add_char(rand_word_ch());
         end
         9, 10, 11: begin
            repeat ($urandom_range(1, 4)) add_char(8'(8'h30 + $urandom_range(0, 9)));
            if ($urandom_range(0, 1)) begin
               add_char(CH_DOT);
               repeat ($urandom_range(0, 3)) add_char(8'(8'h30 + $urandom_range(0, 9)));
            end
         end
         12, 13, 14: begin
            add_char(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
               c = 8'($urandom_range(0, 255));
               if ($urandom_range(0, 2) == 0) c = CH_NEWLINE;
               if (c == CH_QUOTE) c = 8'h20;
               add_char(c);
            end
            if ($urandom_range(0, 6) != 0) add_char(CH_QUOTE);
         end
         15, 16: add_char($urandom_range(0, 1) ? CH_SEMI : CH_STAR);
         17, 18: add_char(8'($urandom_range(0, 255)));
         19, 20, 21: add_char($urandom_range(0, 1) ? 8'h20 : CH_NEWLINE);
         default: add_end(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 9) < 6) begin
         case ($urandom_range(0, 6))
            0: add_char(8'h20);
            1: add_char(8'h09);
            2: add_char(CH_NEWLINE);
            3: add_char(CH_SEMI);
            4: add_char(CH_STAR);
            5: add_char(8'h2C);
            default: add_char(8'h28);
         endcase
      end
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      src_request_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (req_pend_q.size() > 0) begin
            it = req_pend_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= it.ch;
            req_tuser <= it.func;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 32);
               gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // token sink back-pressure
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0, 1: rsp_tready <= 1'b1;
         2: rsp_tready <= $urandom_range(0, 99) < 60;
         default: rsp_tready <= $urandom_range(0, 99) < 15;
      endcase
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            lex_request(func_type'(req_tuser), req_tdata);
            n_req++;
            if (req_tuser == FUNC_END) n_src++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = token_kind_type'(rsp_tuser);
            got.start_offset = rsp_tdata[15:0];
            got.token_length = rsp_tdata[31:16];
            got.line_number = rsp_tdata[47:32];
            got.last_of_run = rsp_tlast;
            n_tok++;
            kind_seen[got.kind] = 1'b1;
            if (tokens_due.size() == 0) begin
               n_err++;
               if (n_err <= 10)
                  $display("%0t: unexpected token kind=%0d start=%0d len=%0d line=%0d last=%0b",
                           $realtime, got.kind, got.start_offset, got.token_length,
                           got.line_number, got.last_of_run);
            end else begin
               want = tokens_due.pop_front();
               if (got.kind !== want.kind || got.start_offset !== want.start_offset ||
                   got.token_length !== want.token_length ||
                   got.line_number !== want.line_number ||
                   got.last_of_run !== want.last_of_run) begin
                  n_err++;
                  if (n_err <= 10)
                     $display({"%0t: token mismatch exp kind=%0d start=%0d len=%0d line=%0d ",
                               "last=%0b got kind=%0d start=%0d len=%0d line=%0d last=%0b"},
                              $realtime, want.kind, want.start_offset, want.token_length,
                              want.line_number, want.last_of_run, got.kind, got.start_offset,
                              got.token_length, got.line_number, got.last_of_run);
               end
            end
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      int base;
      int kinds;
      // directed: keywords, punctuation, string with newline, dot then semicolon,
      // extreme bytes, number with open dot at end, unterminated string at end
      add_text("SELECT*;");
      add_text("\"a\n\"");
      add_text("7.;");
      add_text("INSERT");
      add_char(8'h00);
      add_char(8'hFF);
      add_text("5.");
      add_end(8'h00);
      add_char(CH_QUOTE);
      add_end(8'hFF);

      base = req_pend_q.size();
      while (req_pend_q.size() - base < RANDOM_REQUESTS) add_fragment();
      add_end(8'($urandom_range(0, 255)));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (req_pend_q.size() != 0 || req_tvalid || tokens_due.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      kinds = 0;
      foreach (kind_seen[i]) kinds += kind_seen[i];
      $display("run: %0d requests over %0d sources, %0d tokens compared, %0d of 8 kinds seen",
               n_req, n_src, n_tok, kinds);
      $display("run: keywords, numbers, strings and punctuation under bursty input and stalled output; %0d errors",
               n_err);
      if (n_err == 0 && tokens_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("timeout: %0d requests pending, %0d tokens outstanding",
               req_pend_q.size(), tokens_due.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/qts_pkg.sv
hdl/qts_scan.sv
hdl/qts_rsp_fifo.sv
hdl/query_token_scanner_top.sv
dv/tb_query_token_scanner_top.sv
